### design/cgpb_pkg.sv
package cgpb_pkg;

   localparam int FRAC_BITS          = 12;
   localparam int Q12_WIDTH          = FRAC_BITS + 1;
   localparam int PIX_WIDTH          = 16;
   localparam int BYTE_WIDTH         = 8;
   localparam int CHANNELS           = 3;
   localparam int CSR_INDEX_WIDTH    = 3;
   localparam int CSR_DATA_WIDTH     = Q12_WIDTH;
   localparam int DIV_BITS_PER_STAGE = 2;
   localparam int DIV_STAGES         = FRAC_BITS / DIV_BITS_PER_STAGE;
   localparam int SQ_WIDTH           = 2 * Q12_WIDTH;
   localparam int W_WIDTH            = Q12_WIDTH + 1;
   localparam int P_WIDTH            = SQ_WIDTH + W_WIDTH;
   localparam int PROD_WIDTH         = PIX_WIDTH + W_WIDTH;
   localparam int Q24_WIDTH          = 2 * FRAC_BITS + 1;

   localparam logic [Q12_WIDTH-1:0] ONE_Q12      = Q12_WIDTH'(1) << FRAC_BITS;
   localparam logic [W_WIDTH-1:0]   THREE_Q12    = W_WIDTH'(3) << FRAC_BITS;
   localparam logic [Q24_WIDTH-1:0] ONE_Q24      = Q24_WIDTH'(1) << (2 * FRAC_BITS);
   localparam logic [P_WIDTH-1:0]   ROUND_GATE   = P_WIDTH'(1) << (2 * FRAC_BITS - 1);

   localparam logic                  GATE_ENABLE_RESET = 1'b0;
   localparam logic [Q12_WIDTH-1:0] GATE_LOW_RESET    = 13'd1843;
   localparam logic [Q12_WIDTH-1:0] GATE_HIGH_RESET   = 13'd2662;
   localparam logic [Q12_WIDTH-1:0] CULL_RESET        = 13'd2048;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_GATE_ENABLE = 3'd0,
      CSR_GATE_LOW    = 3'd1,
      CSR_GATE_HIGH   = 3'd2,
      CSR_CULL_RED    = 3'd3,
      CSR_CULL_GREEN  = 3'd4,
      CSR_CULL_BLUE   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [PIX_WIDTH-1:0] pixel_red;
      logic signed [PIX_WIDTH-1:0] pixel_green;
      logic signed [PIX_WIDTH-1:0] pixel_blue;
      logic signed [PIX_WIDTH-1:0] pixel_alpha;
      logic signed [PIX_WIDTH-1:0] confidence;
   } req_payload_type;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] out_red;
      logic [BYTE_WIDTH-1:0] out_green;
      logic [BYTE_WIDTH-1:0] out_blue;
      logic [BYTE_WIDTH-1:0] out_alpha;
      logic [BYTE_WIDTH-1:0] confidence_byte;
   } rsp_payload_type;

   // fields that ride along with a pixel through the pipeline
   typedef struct packed {
      logic                                 gate_en;
      logic                                 degen;
      logic                                 hard;
      logic                                 sat;
      logic [CHANNELS-1:0][PIX_WIDTH-1:0]   pix;
      logic [CHANNELS:0][BYTE_WIDTH-1:0]    pass_byte;
      logic [BYTE_WIDTH-1:0]                conf_byte;
   } side_type;

   // clamp a signed Q3.12 value to 0..1, round half up to a byte
   function automatic logic [BYTE_WIDTH-1:0] byte_q12(input logic signed [PIX_WIDTH-1:0] x);
      logic [Q12_WIDTH-1:0]              u;
      logic [Q12_WIDTH+BYTE_WIDTH-1:0]   acc;
      if (x < 0) begin
         u = '0;
      end else if (x > $signed(PIX_WIDTH'(ONE_Q12))) begin
         u = ONE_Q12;
      end else begin
         u = x[Q12_WIDTH-1:0];
      end
      acc = {u, BYTE_WIDTH'(0)} - {BYTE_WIDTH'(0), u}
            + ((Q12_WIDTH+BYTE_WIDTH)'(1) << (FRAC_BITS - 1));
      return acc[FRAC_BITS+BYTE_WIDTH-1:FRAC_BITS];
   endfunction

   // round an already clamped Q24 value (0..1) half up to a byte
   function automatic logic [BYTE_WIDTH-1:0] byte_q24(input logic [Q24_WIDTH-1:0] u);
      logic [Q24_WIDTH+BYTE_WIDTH-1:0] acc;
      acc = {u, BYTE_WIDTH'(0)} - {BYTE_WIDTH'(0), u}
            + ((Q24_WIDTH+BYTE_WIDTH)'(1) << (2 * FRAC_BITS - 1));
      return acc[2*FRAC_BITS+BYTE_WIDTH-1:2*FRAC_BITS];
   endfunction

endpackage

### design/cgpb_stream_if.sv
interface cgpb_stream_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

### design/confidence_gated_pixel_blend_top.sv
// Confidence-gated pixel blend.
// req_if carries one pixel per beat (signed Q3.12 red, green, blue, alpha and
// confidence); rsp_if returns one beat per pixel with five bytes. The csr port
// writes one register per cycle at csr_index when csr_we is high; write it only
// while no pixel is in flight.
// Throughput: one pixel per cycle while results are taken. Depth: fifteen
// register stages. The length is set by the gate path: a six-stage divider
// (two quotient bits per stage), the two smoothstep multiplies and the
// per-channel blend multiply, sum, clamp and rounding.
// The pipeline moves as one while the output skid register is empty. When the
// receiver stalls, the pending result drops into the skid register as the
// pipeline advances, and the pipeline then holds with req_if.ready low until
// the skid beat is taken. Nothing is lost or repeated.
// Reset (synchronous, active high) empties the pipeline and the skid register
// and returns the registers to their reset values: gating off, low 0.45,
// high 0.65, cull colour mid grey.
module confidence_gated_pixel_blend_top (
   input  logic                                  clock,
   input  logic                                  reset,
   cgpb_stream_if.sink                           req_if,
   cgpb_stream_if.source                         rsp_if,
   input  logic                                  csr_we,
   input  logic [cgpb_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [cgpb_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   localparam int FB        = cgpb_pkg::FRAC_BITS;
   localparam int QW        = cgpb_pkg::Q12_WIDTH;
   localparam int PW        = cgpb_pkg::PIX_WIDTH;
   localparam int BW        = cgpb_pkg::BYTE_WIDTH;
   localparam int NCH       = cgpb_pkg::CHANNELS;
   localparam int ST_RAW    = 0;
   localparam int ST_FRONT  = 1;
   localparam int ST_DIV    = ST_FRONT + cgpb_pkg::DIV_STAGES;
   localparam int ST_SQ     = ST_DIV + 1;
   localparam int ST_CUBE   = ST_SQ + 1;
   localparam int ST_GATE   = ST_CUBE + 1;
   localparam int ST_MUL    = ST_GATE + 1;
   localparam int ST_SUM    = ST_MUL + 1;
   localparam int ST_CLAMP  = ST_SUM + 1;
   localparam int ST_OUT    = ST_CLAMP + 1;

   // registers
   logic                gate_enable_ff;
   logic [QW-1:0]       gate_low_ff;
   logic [QW-1:0]       gate_high_ff;
   logic [QW-1:0]       cull_ff [NCH];

   // pipeline control
   logic                advance;
   logic                v_ff [ST_OUT+1];
   logic                skid_v_ff;
   logic                skid_v_in;
   cgpb_pkg::rsp_payload_type skid_ff;

   // payload
   cgpb_pkg::req_payload_type raw_ff;
   logic                raw_en_ff;
   cgpb_pkg::side_type  side_ff [ST_FRONT:ST_CLAMP];
   cgpb_pkg::side_type  front_side_in;
   logic [QW-1:0]       front_num;
   logic [QW-1:0]       rem_ff [ST_FRONT:ST_DIV];
   logic [QW-1:0]       rem_in [ST_FRONT:ST_DIV];
   logic [FB-1:0]       q_ff [ST_FRONT:ST_DIV];
   logic [FB-1:0]       q_in [ST_FRONT:ST_DIV];
   logic [QW-1:0]       den;
   logic [QW-1:0]       t_in;
   logic [cgpb_pkg::SQ_WIDTH-1:0] tt_ff;
   logic [cgpb_pkg::SQ_WIDTH-1:0] tt_in;
   logic [cgpb_pkg::W_WIDTH-1:0]  w_ff;
   logic [cgpb_pkg::W_WIDTH-1:0]  w_in;
   logic [cgpb_pkg::P_WIDTH-1:0]  p_ff;
   logic [cgpb_pkg::P_WIDTH-1:0]  p_in;
   logic [cgpb_pkg::P_WIDTH-1:0]  p_round;
   logic [QW-1:0]       g_ff;
   logic [QW-1:0]       g_in;
   logic [BW-1:0]       gbyte_ff [ST_MUL:ST_CLAMP];
   logic signed [cgpb_pkg::PROD_WIDTH-1:0] prod_ff [NCH];
   logic signed [cgpb_pkg::PROD_WIDTH-1:0] prod_in [NCH];
   logic [cgpb_pkg::SQ_WIDTH-1:0] cullp_ff [NCH];
   logic [cgpb_pkg::SQ_WIDTH-1:0] cullp_in [NCH];
   logic signed [cgpb_pkg::PROD_WIDTH-1:0] sum_ff [NCH];
   logic signed [cgpb_pkg::PROD_WIDTH-1:0] sum_in [NCH];
   logic [cgpb_pkg::Q24_WIDTH-1:0] u_ff [NCH];
   logic [cgpb_pkg::Q24_WIDTH-1:0] u_in [NCH];
   cgpb_pkg::rsp_payload_type out_ff;
   cgpb_pkg::rsp_payload_type out_in;

   // ---------------------------------------------------------------- csr
   always_ff @(posedge clock) begin
      if (reset) begin
         gate_enable_ff <= cgpb_pkg::GATE_ENABLE_RESET;
         gate_low_ff    <= cgpb_pkg::GATE_LOW_RESET;
         gate_high_ff   <= cgpb_pkg::GATE_HIGH_RESET;
         for (int c = 0; c < NCH; c++) begin
            cull_ff[c] <= cgpb_pkg::CULL_RESET;
         end
      end else if (csr_we) begin
         unique case (csr_index)
            cgpb_pkg::CSR_GATE_ENABLE: gate_enable_ff <= csr_wdata[0];
            cgpb_pkg::CSR_GATE_LOW:    gate_low_ff    <= csr_wdata;
            cgpb_pkg::CSR_GATE_HIGH:   gate_high_ff   <= csr_wdata;
            cgpb_pkg::CSR_CULL_RED:    cull_ff[0]     <= csr_wdata;
            cgpb_pkg::CSR_CULL_GREEN:  cull_ff[1]     <= csr_wdata;
            cgpb_pkg::CSR_CULL_BLUE:   cull_ff[2]     <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign den = gate_high_ff - gate_low_ff;

   // ---------------------------------------------------------------- handshake
   assign advance       = !skid_v_ff;
   assign req_if.ready  = advance;
   assign rsp_if.valid  = skid_v_ff || v_ff[ST_OUT];
   assign rsp_if.payload = skid_v_ff ? skid_ff : out_ff;

   always_comb begin
      skid_v_in = skid_v_ff;
      if (skid_v_ff && rsp_if.ready) begin
         skid_v_in = 1'b0;
      end else if (advance && v_ff[ST_OUT] && !rsp_if.ready) begin
         skid_v_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_v_ff <= 1'b0;
         for (int k = 0; k <= ST_OUT; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else begin
         skid_v_ff <= skid_v_in;
         if (advance) begin
            v_ff[ST_RAW] <= req_if.valid;
            for (int k = 1; k <= ST_OUT; k++) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && v_ff[ST_OUT] && !rsp_if.ready) begin
         skid_ff <= out_ff;
      end
   end

   // ---------------------------------------------------------------- front end
   always_comb begin
      logic signed [PW-1:0] c;
      logic [QW-1:0]        cv;
      logic [QW-1:0]        num;
      c = raw_ff.confidence;
      if (c < 0) begin
         cv = '0;
      end else if (c > $signed(PW'(cgpb_pkg::ONE_Q12))) begin
         cv = cgpb_pkg::ONE_Q12;
      end else begin
         cv = c[QW-1:0];
      end
      num = (cv > gate_low_ff) ? cv - gate_low_ff : '0;
      front_side_in.gate_en      = raw_en_ff;
      front_side_in.degen        = gate_high_ff <= gate_low_ff;
      front_side_in.hard         = cv >= gate_low_ff;
      front_side_in.sat          = num >= den;
      front_side_in.pix[0]       = raw_ff.pixel_red;
      front_side_in.pix[1]       = raw_ff.pixel_green;
      front_side_in.pix[2]       = raw_ff.pixel_blue;
      front_side_in.pass_byte[0] = cgpb_pkg::byte_q12(raw_ff.pixel_red);
      front_side_in.pass_byte[1] = cgpb_pkg::byte_q12(raw_ff.pixel_green);
      front_side_in.pass_byte[2] = cgpb_pkg::byte_q12(raw_ff.pixel_blue);
      front_side_in.pass_byte[3] = cgpb_pkg::byte_q12(raw_ff.pixel_alpha);
      front_side_in.conf_byte    = cgpb_pkg::byte_q12($signed(PW'(cv)));
      front_num                  = num;
   end

   // ---------------------------------------------------------------- divider
   // restoring division, DIV_BITS_PER_STAGE quotient bits per stage
   always_comb begin
      logic [QW-1:0] r;
      logic [QW:0]   r2;
      logic [FB-1:0] q;
      rem_in[ST_FRONT] = front_num;
      q_in[ST_FRONT]   = '0;
      for (int k = ST_FRONT + 1; k <= ST_DIV; k++) begin
         r = rem_ff[k-1];
         q = q_ff[k-1];
         for (int b = 0; b < cgpb_pkg::DIV_BITS_PER_STAGE; b++) begin
            r2 = {r, 1'b0};
            if (r2 >= {1'b0, den}) begin
               r2 = r2 - {1'b0, den};
               q  = {q[FB-2:0], 1'b1};
            end else begin
               q  = {q[FB-2:0], 1'b0};
            end
            r = r2[QW-1:0];
         end
         rem_in[k] = r;
         q_in[k]   = q;
      end
   end

   // ---------------------------------------------------------------- smoothstep
   assign t_in    = side_ff[ST_DIV].sat ? cgpb_pkg::ONE_Q12 : {1'b0, q_ff[ST_DIV]};
   assign tt_in   = {{QW{1'b0}}, t_in} * {{QW{1'b0}}, t_in};
   assign w_in    = cgpb_pkg::THREE_Q12 - {t_in, 1'b0};
   assign p_in    = {{cgpb_pkg::W_WIDTH{1'b0}}, tt_ff} * {{cgpb_pkg::SQ_WIDTH{1'b0}}, w_ff};
   assign p_round = p_ff + cgpb_pkg::ROUND_GATE;

   always_comb begin
      if (side_ff[ST_CUBE].degen) begin
         g_in = side_ff[ST_CUBE].hard ? cgpb_pkg::ONE_Q12 : '0;
      end else begin
         g_in = p_round[2*FB+QW-1:2*FB];
      end
   end

   // ---------------------------------------------------------------- blend lanes
   always_comb begin
      for (int c = 0; c < NCH; c++) begin
         prod_in[c]  = $signed(side_ff[ST_GATE].pix[c]) * $signed({1'b0, g_ff});
         cullp_in[c] = {{QW{1'b0}}, cull_ff[c]} * {{QW{1'b0}}, cgpb_pkg::ONE_Q12 - g_ff};
         sum_in[c]   = prod_ff[c]
                       + $signed({{(cgpb_pkg::PROD_WIDTH-cgpb_pkg::SQ_WIDTH){1'b0}},
                                  cullp_ff[c]});
         if (sum_ff[c] < 0) begin
            u_in[c] = '0;
         end else if (sum_ff[c] > $signed(cgpb_pkg::PROD_WIDTH'(cgpb_pkg::ONE_Q24))) begin
            u_in[c] = cgpb_pkg::ONE_Q24;
         end else begin
            u_in[c] = sum_ff[c][cgpb_pkg::Q24_WIDTH-1:0];
         end
      end
   end

   // ---------------------------------------------------------------- output
   always_comb begin
      if (side_ff[ST_CLAMP].gate_en) begin
         out_in.out_red         = cgpb_pkg::byte_q24(u_ff[0]);
         out_in.out_green       = cgpb_pkg::byte_q24(u_ff[1]);
         out_in.out_blue        = cgpb_pkg::byte_q24(u_ff[2]);
         out_in.out_alpha       = gbyte_ff[ST_CLAMP];
         out_in.confidence_byte = side_ff[ST_CLAMP].conf_byte;
      end else begin
         out_in.out_red         = side_ff[ST_CLAMP].pass_byte[0];
         out_in.out_green       = side_ff[ST_CLAMP].pass_byte[1];
         out_in.out_blue        = side_ff[ST_CLAMP].pass_byte[2];
         out_in.out_alpha       = side_ff[ST_CLAMP].pass_byte[3];
         out_in.confidence_byte = '0;
      end
   end

   // ---------------------------------------------------------------- datapath regs
   always_ff @(posedge clock) begin
      if (advance) begin
         raw_ff    <= req_if.payload;
         raw_en_ff <= gate_enable_ff;
         side_ff[ST_FRONT] <= front_side_in;
         for (int k = ST_FRONT + 1; k <= ST_CLAMP; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
         for (int k = ST_FRONT; k <= ST_DIV; k++) begin
            rem_ff[k] <= rem_in[k];
            q_ff[k]   <= q_in[k];
         end
         tt_ff <= tt_in;
         w_ff  <= w_in;
         p_ff  <= p_in;
         g_ff  <= g_in;
         gbyte_ff[ST_MUL] <= cgpb_pkg::byte_q12($signed(PW'(g_ff)));
         for (int k = ST_MUL + 1; k <= ST_CLAMP; k++) begin
            gbyte_ff[k] <= gbyte_ff[k-1];
         end
         for (int c = 0; c < NCH; c++) begin
            prod_ff[c]  <= prod_in[c];
            cullp_ff[c] <= cullp_in[c];
            sum_ff[c]   <= sum_in[c];
            u_ff[c]     <= u_in[c];
         end
         out_ff <= out_in;
      end
   end

endmodule

### tb/tb_confidence_gated_pixel_blend_top.sv
module tb_confidence_gated_pixel_blend_top;
   import cgpb_pkg::*;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_LOW  = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_HIGH = 3'd7;
   localparam int RANDOM_PHASES  = 14;
   localparam int PHASE_PIXELS   = 135;
   localparam int PRESSURE_PHASE = 5;
   localparam int HOLD_CYCLES    = 400;
   localparam int MAX_LEVEL      = 8191;

   logic                       clock     = 1'b0;
   logic                       reset     = 1'b1;
   logic                       req_valid = 1'b0;
   req_payload_type            req_data  = '0;
   logic                       rsp_ready = 1'b0;
   logic                       csr_we    = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   cgpb_stream_if #(.payload_type(req_payload_type)) req_bus ();
   cgpb_stream_if #(.payload_type(rsp_payload_type)) rsp_bus ();

   assign req_bus.valid   = req_valid;
   assign req_bus.payload = req_data;
   assign rsp_bus.ready   = rsp_ready;

   confidence_gated_pixel_blend_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // local copy of the register file
   logic                 gate_on = GATE_ENABLE_RESET;
   logic [Q12_WIDTH-1:0] gate_lo = GATE_LOW_RESET;
   logic [Q12_WIDTH-1:0] gate_hi = GATE_HIGH_RESET;
   logic [Q12_WIDTH-1:0] cull_level [CHANNELS] = '{CULL_RESET, CULL_RESET, CULL_RESET};

   req_payload_type pixel_backlog [$];
   rsp_payload_type expected_bytes [$];

   logic req_took  = 1'b0;
   logic quiet     = 1'b0;
   logic want_hold = 1'b0;
   logic hold_done = 1'b0;
   int   send_gap   = 0;
   int   stall_left = 0;
   int   hold_left  = 0;
   int   idle_odds  = 8;
   int   mismatches = 0;

   logic [4:0][BYTE_WIDTH-1:0] want_b;
   logic [4:0][BYTE_WIDTH-1:0] got_b;
   string field_name [5] = '{"confidence_byte", "out_alpha", "out_blue", "out_green",
                             "out_red"};

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // clamp to 0..1 with fb fraction bits, round half up to a byte
   function automatic logic [BYTE_WIDTH-1:0] unit_byte(longint x, int fb);
      longint one;
      one = longint'(1) << fb;
      if (x < 0) x = 0;
      if (x > one) x = one;
      return BYTE_WIDTH'((x * 255 + (longint'(1) << (fb - 1))) >> fb);
   endfunction

   function automatic rsp_payload_type blend_by_confidence(req_payload_type px);
      rsp_payload_type       r;
      longint                colour [CHANNELS];
      longint                one_q, cv, lo, hi, t, g;
      logic [BYTE_WIDTH-1:0] bytes [CHANNELS];
      one_q     = longint'(ONE_Q12);
      colour[0] = longint'(px.pixel_red);
      colour[1] = longint'(px.pixel_green);
      colour[2] = longint'(px.pixel_blue);
      if (!gate_on) begin
         for (int i = 0; i < CHANNELS; i++) bytes[i] = unit_byte(colour[i], FRAC_BITS);
         r.out_alpha       = unit_byte(longint'(px.pixel_alpha), FRAC_BITS);
         r.confidence_byte = '0;
      end else begin
         cv = longint'(px.confidence);
         if (cv < 0) cv = 0;
         if (cv > one_q) cv = one_q;
         lo = longint'(gate_lo);
         hi = longint'(gate_hi);
         if (hi <= lo) begin
            g = (cv >= lo) ? one_q : 0;
         end else begin
            t = (cv > lo) ? cv - lo : 0;
            t = (t >= hi - lo) ? one_q : (t * one_q) / (hi - lo);
            g = (t * t * (3 * one_q - 2 * t) + (longint'(1) << 23)) >> 24;
         end
         for (int i = 0; i < CHANNELS; i++) begin
            bytes[i] = unit_byte(colour[i] * g + longint'(cull_level[i]) * (one_q - g),
                                 2 * FRAC_BITS);
         end
         r.out_alpha       = unit_byte(g, FRAC_BITS);
         r.confidence_byte = unit_byte(cv, FRAC_BITS);
      end
      r.out_red   = bytes[0];
      r.out_green = bytes[1];
      r.out_blue  = bytes[2];
      return r;
   endfunction

   function automatic logic [PIX_WIDTH-1:0] random_colour();
      case ($urandom_range(0, 3))
         0: return PIX_WIDTH'($urandom);
         1: return PIX_WIDTH'($urandom_range(0, 4096));
         2: return PIX_WIDTH'(int'($urandom_range(0, 6144)) - 1024);
         default: return PIX_WIDTH'(int'($urandom_range(0, 4)) * 2048 - 2048);
      endcase
   endfunction

   function automatic logic [PIX_WIDTH-1:0] random_confidence();
      int lo, hi;
      lo = int'(gate_lo);
      hi = int'(gate_hi);
      case ($urandom_range(0, 4))
         0: return PIX_WIDTH'($urandom);
         1: return PIX_WIDTH'($urandom_range(0, 4096));
         2: return PIX_WIDTH'(lo + int'($urandom_range(0, 8)) - 4);
         3: return PIX_WIDTH'(hi + int'($urandom_range(0, 8)) - 4);
         default: begin
            if (hi > lo) return PIX_WIDTH'(lo + int'($urandom_range(0, hi - lo)));
            return PIX_WIDTH'($urandom_range(0, 4096));
         end
      endcase
   endfunction

   function automatic int pick_level();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return 4096;
         2: return $urandom_range(4097, MAX_LEVEL);
         default: return $urandom_range(0, 4096);
      endcase
   endfunction

   task automatic queue_pixel(int r, int g, int b, int a, int c);
      req_payload_type px;
      px.pixel_red   = PIX_WIDTH'(r);
      px.pixel_green = PIX_WIDTH'(g);
      px.pixel_blue  = PIX_WIDTH'(b);
      px.pixel_alpha = PIX_WIDTH'(a);
      px.confidence  = PIX_WIDTH'(c);
      pixel_backlog.push_back(px);
   endtask

   task automatic queue_random_pixel();
      req_payload_type px;
      px.pixel_red   = random_colour();
      px.pixel_green = random_colour();
      px.pixel_blue  = random_colour();
      px.pixel_alpha = random_colour();
      px.confidence  = random_confidence();
      pixel_backlog.push_back(px);
   endtask

   task automatic drain();
      while (pixel_backlog.size() != 0 || expected_bytes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_WIDTH-1:0] idx,
                            logic [CSR_DATA_WIDTH-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_GATE_ENABLE: gate_on       = value[0];
         CSR_GATE_LOW:    gate_lo       = value;
         CSR_GATE_HIGH:   gate_hi       = value;
         CSR_CULL_RED:    cull_level[0] = value;
         CSR_CULL_GREEN:  cull_level[1] = value;
         CSR_CULL_BLUE:   cull_level[2] = value;
         default: ;
      endcase
   endtask

   task automatic configure(logic en, int lo, int hi, int cr, int cg, int cb);
      drain();
      write_reg(CSR_GATE_ENABLE, {(CSR_DATA_WIDTH-1)'($urandom), en});
      write_reg(CSR_GATE_LOW, CSR_DATA_WIDTH'(lo));
      write_reg(CSR_GATE_HIGH, CSR_DATA_WIDTH'(hi));
      write_reg(CSR_CULL_RED, CSR_DATA_WIDTH'(cr));
      write_reg(CSR_CULL_GREEN, CSR_DATA_WIDTH'(cg));
      write_reg(CSR_CULL_BLUE, CSR_DATA_WIDTH'(cb));
      // unmapped index, must be dropped
      write_reg($urandom_range(0, 1) ? CSR_SPARE_LOW : CSR_SPARE_HIGH,
                CSR_DATA_WIDTH'($urandom));
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // pixel sender
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_took) begin
         req_valid <= 1'b1;
      end else if (!quiet && send_gap != 0) begin
         req_valid <= 1'b0;
         send_gap  <= send_gap - 1;
      end else if (!quiet && $urandom_range(0, idle_odds) == 0) begin
         req_valid <= 1'b0;
         send_gap  <= $urandom_range(0, 18);
      end else if (pixel_backlog.size() != 0) begin
         req_valid <= 1'b1;
         req_data  <= pixel_backlog[0];
      end else begin
         req_valid <= 1'b0;
      end
   end

   // result receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (want_hold && !hold_done) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES - 1;
         hold_done <= 1'b1;
      end else if (!quiet && stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!quiet && $urandom_range(0, idle_odds) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(0, 18);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_took <= 1'b0;
      end else begin
         req_took <= req_bus.valid && req_bus.ready;
         if (req_bus.valid && req_bus.ready) begin
            expected_bytes.push_back(blend_by_confidence(req_bus.payload));
            void'(pixel_backlog.pop_front());
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_bytes.size() == 0) begin
               mismatches++;
               $display("%0t: result beat %h with nothing expected", $time, rsp_bus.payload);
            end else begin
               want_b = expected_bytes.pop_front();
               got_b  = rsp_bus.payload;
               for (int i = 0; i < 5; i++) begin
                  if (want_b[i] !== got_b[i]) begin
                     mismatches++;
                     $display("%0t: %s expected %0d got %0d", $time, field_name[i],
                              want_b[i], got_b[i]);
                  end
               end
            end
         end
      end
   end

   initial begin
      int lo, hi;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // pass-through with reset settings
      queue_pixel(-32768, 32767, 0, 4096, -32768);
      queue_pixel(4095, 4097, -1, 1, 32767);
      queue_pixel(8, 9, 2048, 2056, 4096);

      configure(1'b1, 1843, 2662, 2048, 2048, 2048);
      queue_pixel(32767, -32768, 4096, 0, -32768);
      queue_pixel(0, 4096, 2048, 0, 0);
      queue_pixel(4096, 0, -1, 0, 1842);
      queue_pixel(4097, 100, 4000, 0, 1843);
      queue_pixel(-32768, 32767, 2048, 0, 1844);
      queue_pixel(1000, 3000, 4096, 0, 2252);
      queue_pixel(4096, 4096, 4096, 0, 2661);
      queue_pixel(0, 0, 0, 0, 2662);
      queue_pixel(2048, 2048, 2048, 0, 2663);
      queue_pixel(4096, 0, 32767, 0, 4096);
      queue_pixel(-1, 4095, 1, 0, 4097);
      queue_pixel(32767, 32767, 32767, 32767, 32767);

      // hard step when high is not above low
      configure(1'b1, 2048, 2048, 0, 4096, 8191);
      queue_pixel(4096, 0, 2048, 0, 2047);
      queue_pixel(4096, 0, 2048, 0, 2048);
      configure(1'b1, 3000, 1000, 4096, 0, 2048);
      queue_pixel(0, 4096, 1024, 0, 2999);
      queue_pixel(0, 4096, 1024, 0, 3000);

      // thresholds and cull colour above one
      configure(1'b1, 5000, 8191, 8191, 8191, 8191);
      queue_pixel(0, 0, 0, 0, 4096);
      queue_pixel(4096, -32768, 0, 0, 32767);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: configure(1'b1, 0, 4096, 0, 0, 0);
            1: configure(1'b1, 0, 1, 4096, 4096, 4096);
            2: configure(1'b1, 4095, 4096, 8191, 0, 4096);
            3: configure(1'b1, 4096, 0, 8191, 8191, 8191);
            4: configure(1'b0, 8191, 8191, 0, 8191, 4096);
            default: begin
               if ($urandom_range(0, 3) != 0) begin
                  lo = $urandom_range(0, 4000);
                  hi = lo + int'($urandom_range(1, 4096 - lo));
               end else begin
                  lo = pick_level();
                  hi = pick_level();
               end
               configure($urandom_range(0, 3) != 0, lo, hi, pick_level(), pick_level(),
                         pick_level());
            end
         endcase
         idle_odds = (phase % 3 == 0) ? 3 : ((phase % 3 == 1) ? 12 : 60);
         if (phase == PRESSURE_PHASE) begin
            want_hold = 1'b1;
            idle_odds = 1000;
         end
         if (phase == RANDOM_PHASES - 1) quiet = 1'b1;
         repeat (PHASE_PIXELS) queue_random_pixel();
      end

      drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
